[sv/biou_pkg.sv]
// Shared types, widths and helpers for the box IoU cost block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package biou_pkg;

    localparam int COORD_W = 16;
    localparam int LEN_W   = 15;
    localparam int EDGE_W  = COORD_W + 1;
    localparam int DIFF_W  = COORD_W + 2;
    localparam int AREA_W  = 2 * LEN_W;
    localparam int UNION_W = AREA_W + 1;
    localparam int Q_BITS  = 15;
    localparam int COST_W  = Q_BITS + 1;
    localparam int FRAME_W = 8;
    localparam int IDX_W   = 6;

    localparam logic [COST_W-1:0]  ONE_Q15       = COST_W'(1) << Q_BITS;
    localparam logic [COST_W-1:0]  INF_COST_RST  = '1;
    localparam logic [FRAME_W-1:0] MAX_FRESH_AGE = FRAME_W'(1);

    typedef struct packed {
        logic signed [COORD_W-1:0] track_left;
        logic signed [COORD_W-1:0] track_top;
        logic [LEN_W-1:0]          track_width;
        logic [LEN_W-1:0]          track_height;
        logic signed [COORD_W-1:0] det_left;
        logic signed [COORD_W-1:0] det_top;
        logic [LEN_W-1:0]          det_width;
        logic [LEN_W-1:0]          det_height;
        logic [FRAME_W-1:0]        frames_since_update;
        logic [IDX_W-1:0]          row_index;
        logic [IDX_W-1:0]          column_index;
    } t_in_item;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              degenerate;
        logic [IDX_W-1:0]  row_out;
        logic [IDX_W-1:0]  column_out;
    } t_out_item;

    // Per-item flags and indices that ride along the pipeline.
    typedef struct packed {
        logic             stale;
        logic             degen;
        logic             full;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

    // Restoring divider state: divisor, partial remainder, quotient so far.
    typedef struct packed {
        logic [UNION_W-1:0] divisor;
        logic [UNION_W-1:0] rem;
        logic [Q_BITS-1:0]  quo;
    } t_div;

    // Overlap length along one axis, clamped at zero.
    function automatic logic [LEN_W-1:0] overlap_len(
        input logic signed [COORD_W-1:0] a_lo,
        input logic [LEN_W-1:0]          a_len,
        input logic signed [COORD_W-1:0] b_lo,
        input logic [LEN_W-1:0]          b_len
    );
        logic signed [EDGE_W-1:0] a_lo_x;
        logic signed [EDGE_W-1:0] b_lo_x;
        logic signed [EDGE_W-1:0] a_hi;
        logic signed [EDGE_W-1:0] b_hi;
        logic signed [EDGE_W-1:0] lo;
        logic signed [EDGE_W-1:0] hi;
        logic signed [DIFF_W-1:0] diff;
        a_lo_x = EDGE_W'(a_lo);
        b_lo_x = EDGE_W'(b_lo);
        a_hi   = a_lo_x + $signed({2'b00, a_len});
        b_hi   = b_lo_x + $signed({2'b00, b_len});
        lo     = (a_lo_x > b_lo_x) ? a_lo_x : b_lo_x;
        hi     = (a_hi < b_hi) ? a_hi : b_hi;
        diff   = DIFF_W'(hi) - DIFF_W'(lo);
        overlap_len = (diff > 0) ? diff[LEN_W-1:0] : '0;
    endfunction

endpackage

[sv/biou_if.sv]
// Valid/ready channel interfaces for input items, result items and config.
// Depends on biou_pkg for the payload types.
`timescale 1ns / 1ps

interface biou_in_if;
    import biou_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface biou_out_if;
    import biou_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface biou_cfg_if;
    import biou_pkg::*;
    logic              valid;
    logic              ready;
    logic [COST_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/biou_geom.sv]
// Three-stage front end: axis overlaps, box areas, union and special-case flags.
// Depends on biou_pkg.
`timescale 1ns / 1ps

module biou_geom (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  biou_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output biou_pkg::t_tag    o_tag,
    output biou_pkg::t_div    o_div
);
    import biou_pkg::*;

    logic r_a_valid, r_b_valid, r_c_valid;
    logic a_ready, b_ready, c_ready;

    // stage A: overlaps
    t_tag             r_a_tag;
    logic [LEN_W-1:0] r_a_ox, r_a_oy;
    logic [LEN_W-1:0] r_a_tw, r_a_th, r_a_dw, r_a_dh;
    // stage B: areas
    t_tag              r_b_tag;
    logic [AREA_W-1:0] r_b_inter, r_b_ta, r_b_da;
    // stage C: union and divider seed
    t_tag r_c_tag;
    t_div r_c_div;

    t_tag               n_a_tag;
    t_tag               n_c_tag;
    logic [UNION_W-1:0] n_union;

    assign c_ready = !r_c_valid || i_ready;
    assign b_ready = !r_b_valid || c_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    always_comb begin
        n_a_tag       = '0;
        n_a_tag.stale = i_item.frames_since_update > MAX_FRESH_AGE;
        n_a_tag.row   = i_item.row_index;
        n_a_tag.col   = i_item.column_index;
    end

    always_comb begin
        n_union       = UNION_W'(r_b_ta) + UNION_W'(r_b_da) - UNION_W'(r_b_inter);
        n_c_tag       = r_b_tag;
        n_c_tag.degen = !r_b_tag.stale && (n_union == '0);
        n_c_tag.full  = !r_b_tag.stale && (n_union != '0)
                        && (n_union == UNION_W'(r_b_inter));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_tag <= n_a_tag;
            r_a_ox  <= overlap_len(i_item.track_left, i_item.track_width,
                                   i_item.det_left, i_item.det_width);
            r_a_oy  <= overlap_len(i_item.track_top, i_item.track_height,
                                   i_item.det_top, i_item.det_height);
            r_a_tw  <= i_item.track_width;
            r_a_th  <= i_item.track_height;
            r_a_dw  <= i_item.det_width;
            r_a_dh  <= i_item.det_height;
        end
        if (b_ready && r_a_valid) begin
            r_b_tag   <= r_a_tag;
            r_b_inter <= r_a_ox * r_a_oy;
            r_b_ta    <= r_a_tw * r_a_th;
            r_b_da    <= r_a_dw * r_a_dh;
        end
        if (c_ready && r_b_valid) begin
            r_c_tag         <= n_c_tag;
            r_c_div.divisor <= n_union;
            r_c_div.rem     <= UNION_W'(r_b_inter);
            r_c_div.quo     <= '0;
        end
    end

    assign o_valid = r_c_valid;
    assign o_tag   = r_c_tag;
    assign o_div   = r_c_div;

endmodule

[sv/biou_div_step.sv]
// One registered step of the restoring divider: one quotient bit per stage.
// Depends on biou_pkg.
`timescale 1ns / 1ps

module biou_div_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  biou_pkg::t_tag i_tag,
    input  biou_pkg::t_div i_div,
    output logic           o_valid,
    input  logic           i_ready,
    output biou_pkg::t_tag o_tag,
    output biou_pkg::t_div o_div
);
    import biou_pkg::*;

    logic               r_valid;
    t_tag               r_tag;
    t_div               r_div;
    t_div               n_div;
    logic [UNION_W:0]   shifted;
    logic [UNION_W:0]   divisor_x;
    logic               ge;
    logic [UNION_W:0]   rem_next;

    assign o_ready = !r_valid || i_ready;

    // Double the remainder, subtract the divisor when it fits.
    always_comb begin
        shifted     = {i_div.rem, 1'b0};
        divisor_x   = {1'b0, i_div.divisor};
        ge          = shifted >= divisor_x;
        rem_next    = ge ? (shifted - divisor_x) : shifted;
        n_div       = i_div;
        n_div.rem   = rem_next[UNION_W-1:0];
        n_div.quo   = {i_div.quo[Q_BITS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_tag <= i_tag;
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_div   = r_div;

endmodule

[sv/box_iou_cost.sv]
// box_iou_cost: one track/detection pair in, one cost (1 - IoU, Q1.15) out.
// 19 register stages (3 geometry, 15 divider, 1 output), the first loaded at
// the accept edge. Throughput: one item per cycle while the output is not
// stalled. The 15-stage restoring divider, one quotient bit per stage, sets
// the depth.
// Reset (synchronous, active low) empties the pipeline and sets infinity_cost
// to 0xFFFF; no clearing pass is needed, the block is ready right after reset.
`timescale 1ns / 1ps

module box_iou_cost (
    input  logic       i_clk,
    input  logic       i_rst_n,
    biou_in_if.sink    i_in,
    biou_cfg_if.sink   i_cfg,
    biou_out_if.source o_out
);
    import biou_pkg::*;

    // Configuration: infinity cost, always writable.
    logic [COST_W-1:0] r_inf_cost;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inf_cost <= INF_COST_RST;
        end else if (i_cfg.valid) begin
            r_inf_cost <= i_cfg.data;
        end
    end

    // Pipeline links: index 0 is the geometry output, index Q_BITS the last
    // divider stage. Each stage holds its item until the next one has room.
    logic w_valid [Q_BITS+1];
    logic w_ready [Q_BITS+1];
    t_tag w_tag   [Q_BITS+1];
    t_div w_div   [Q_BITS+1];

    biou_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_item  (i_in.data),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_tag   (w_tag[0]),
        .o_div   (w_div[0])
    );

    for (genvar g = 0; g < Q_BITS; g++) begin : g_div
        biou_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_tag   (w_tag[g]),
            .i_div   (w_div[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_tag   (w_tag[g+1]),
            .o_div   (w_div[g+1])
        );
    end

    // Output register: pick the cost and hold the item until taken.
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;
    t_tag      last_tag;

    assign last_tag              = w_tag[Q_BITS];
    assign w_ready[Q_BITS]       = !r_out_valid || o_out.ready;

    always_comb begin
        n_out.degenerate = last_tag.degen;
        n_out.row_out    = last_tag.row;
        n_out.column_out = last_tag.col;
        if (last_tag.stale || last_tag.degen) begin
            n_out.cost = r_inf_cost;
        end else if (last_tag.full) begin
            // Identical boxes: IoU is exactly one.
            n_out.cost = '0;
        end else begin
            n_out.cost = ONE_Q15 - {1'b0, w_div[Q_BITS].quo};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready[Q_BITS]) begin
            r_out_valid <= w_valid[Q_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[Q_BITS] && w_valid[Q_BITS]) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule
